// File: hdl/lms_pkg.sv
// Shared types and constants for the max-subarray total block.
// Holds the generator constants, register indexes, reset values and the
// command/status structs between controller and datapath. No dependencies.
package lms_pkg;

  // Generator word width and divider step counter width
  localparam int DRAW_W    = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic [DRAW_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [DRAW_W-1:0] LCG_ADD = 32'd1013904223;

  // Register file layout
  localparam int ECOUNT_W = 21;
  localparam int RCOUNT_W = 8;
  localparam int INDEX_W  = 2;
  localparam int TOTAL_W  = 64;

  typedef enum logic [INDEX_W-1:0] {
    REG_ELEMENT_COUNT = 2'd0,
    REG_LOW_BOUND     = 2'd1,
    REG_HIGH_BOUND    = 2'd2,
    REG_RUN_COUNT     = 2'd3
  } reg_index_t;

  localparam logic [ECOUNT_W-1:0] ECOUNT_RESET = 21'd10000;
  localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 8'd20;
  localparam int                  LOW_RESET    = -10;
  localparam int                  HIGH_RESET   = 10;

  // Controller to datapath
  typedef struct packed {
    logic init;
    logic adv_run;
    logic gen;
    logic div_step;
    logic value;
    logic add;
    logic best;
    logic accum;
    logic publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bound_err;
    logic no_runs;
    logic div_last;
    logic last_elem;
    logic last_run;
    logic out_free;
  } status_t;

  // One step of the 32-bit generator, wrapping modulo 2^32
  function automatic logic [DRAW_W-1:0] lcg_next(logic [DRAW_W-1:0] x);
    return x * LCG_MUL + LCG_ADD;
  endfunction

endpackage

// File: hdl/lcg_max_subarray_total.sv
// Sum of maximum subarray sums over runs of generated values.
//
// Channels: a seed channel (seed_valid, seed_stall, start_seed) and a result
// channel (result_valid, result_stall, total_of_maxima, bound_error). A
// transfer happens at a clock edge with valid high and stall low. The
// configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// element_count, low_bound, high_bound and run_count; cfg_ready is always high.
//
// One seed is worked at a time. Each element takes a generator step, the
// bit-serial modulo by the span, then value, suffix add and best compare.
// Each run adds a seed step and an accumulate step. Reversed bounds or a
// zero run count skip the runs and go straight to finish. The result sits
// in an output register; while the receiver stalls it holds, and a new
// seed is still taken. Synchronous reset clears control state and restores
// the configuration defaults; no result is pending after reset.
module lcg_max_subarray_total #(
  parameter int MAX_ELEMENTS = 1048576,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lms_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [((VALUE_WIDTH > lms_pkg::ECOUNT_W) ? VALUE_WIDTH : lms_pkg::ECOUNT_W)-1:0]
                                              cfg_data,
  input  logic                                seed_valid,
  output logic                                seed_stall,
  input  logic [lms_pkg::DRAW_W-1:0]          start_seed,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [lms_pkg::TOTAL_W-1:0]  total_of_maxima,
  output logic                                bound_error
);
  import lms_pkg::*;

  localparam int CFG_W = (VALUE_WIDTH > ECOUNT_W) ? VALUE_WIDTH : ECOUNT_W;

  cmd_t    cmd;
  status_t status;

  // Configuration is to be written only while idle; the block does not enforce this
  assign cfg_ready = 1'b1;

  lms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .seed_valid (seed_valid),
    .seed_stall (seed_stall),
    .status     (status),
    .cmd        (cmd)
  );

  lms_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .CFG_W        (CFG_W)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start_seed      (start_seed),
    .cmd             (cmd),
    .status          (status),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .total_of_maxima (total_of_maxima),
    .bound_error     (bound_error)
  );

endmodule

// File: hdl/lms_ctrl.sv
// Sequencer for the max-subarray total block.
// Walks runs and elements and drives the datapath commands; uses lms_pkg.
module lms_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             seed_valid,
  output logic             seed_stall,
  input  lms_pkg::status_t status,
  output lms_pkg::cmd_t    cmd
);
  import lms_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_SEED   = 10'b0000000100,
    S_GEN    = 10'b0000001000,
    S_DIV    = 10'b0000010000,
    S_VALUE  = 10'b0000100000,
    S_ADD    = 10'b0001000000,
    S_BEST   = 10'b0010000000,
    S_ACCUM  = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // Take a new seed only while idle
  assign seed_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (seed_valid) begin
          cmd.init   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.bound_err || status.no_runs) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd.adv_run = 1'b1;
        state_next  = S_GEN;
      end
      S_GEN: begin
        cmd.gen    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_VALUE;
        end
      end
      S_VALUE: begin
        cmd.value  = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_BEST;
      end
      S_BEST: begin
        cmd.best   = 1'b1;
        state_next = status.last_elem ? S_ACCUM : S_GEN;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.last_run ? S_FINISH : S_SEED;
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/lms_dpath.sv
// Datapath for the max-subarray total block: config registers, generators,
// bit-serial modulo, Kadane recurrence, total and output register. Uses lms_pkg.
module lms_dpath #(
  parameter int MAX_ELEMENTS = 1048576,
  parameter int VALUE_WIDTH  = 16,
  parameter int CFG_W        = 21
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [lms_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic [lms_pkg::DRAW_W-1:0]    start_seed,
  input  lms_pkg::cmd_t                 cmd,
  output lms_pkg::status_t              status,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [lms_pkg::TOTAL_W-1:0] total_of_maxima,
  output logic                          bound_error
);
  import lms_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int RW    = VW + 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CW    = (CNT_W > ECOUNT_W) ? CNT_W : ECOUNT_W;

  // Configuration registers
  logic [ECOUNT_W-1:0]  element_count;
  logic signed [VW-1:0] low_bound;
  logic signed [VW-1:0] high_bound;
  logic [RCOUNT_W-1:0]  run_count;

  // Working state
  logic [DRAW_W-1:0]      run_seed;
  logic [DRAW_W-1:0]      elem_state;
  logic [DRAW_W-1:0]      dividend;
  logic [RW-1:0]          rem;
  logic [RW-1:0]          span;
  logic signed [VW-1:0]   lo;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic signed [VW+1:0]   value;
  logic signed [TOTAL_W-1:0] suffix;
  logic signed [TOTAL_W-1:0] best;
  logic signed [TOTAL_W-1:0] total;
  logic [CW-1:0]          count_m1;
  logic [CW-1:0]          elem_cnt;
  logic [RCOUNT_W-1:0]    run_cnt;

  logic                   err_now;
  logic [CW-1:0]          ec_ext;
  logic [CW-1:0]          count_eff;
  logic [RW-1:0]          span_now;
  logic                   first_elem;
  logic [DRAW_W-1:0]      lcg_src;
  logic [DRAW_W-1:0]      lcg_out;
  logic [RW:0]            trial;
  logic [RW:0]            trial_diff;
  logic signed [TOTAL_W-1:0] value_ext;
  logic signed [TOTAL_W-1:0] suffix_base;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ECOUNT_RESET;
      low_bound     <= VW'(LOW_RESET);
      high_bound    <= VW'(HIGH_RESET);
      run_count     <= RCOUNT_RESET;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_ELEMENT_COUNT: element_count <= cfg_data[ECOUNT_W-1:0];
        REG_LOW_BOUND:     low_bound     <= cfg_data[VW-1:0];
        REG_HIGH_BOUND:    high_bound    <= cfg_data[VW-1:0];
        REG_RUN_COUNT:     run_count     <= cfg_data[RCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Bounds check, span and element count clamp
  assign err_now  = (high_bound < low_bound);
  assign span_now = RW'(high_bound) - RW'(low_bound) + RW'(1);
  assign ec_ext   = CW'(element_count);

  always_comb begin
    if (element_count == '0) begin
      count_eff = CW'(1);
    end else if (ec_ext > CW'(MAX_ELEMENTS)) begin
      count_eff = CW'(MAX_ELEMENTS);
    end else begin
      count_eff = ec_ext;
    end
  end

  // Share one generator step between run seed and element draws
  assign first_elem = (elem_cnt == '0);
  assign lcg_src    = cmd.adv_run ? run_seed : (first_elem ? run_seed : elem_state);
  assign lcg_out    = lcg_next(lcg_src);

  // Restoring modulo step: one dividend bit a cycle
  assign trial      = {rem, dividend[DRAW_W-1]};
  assign trial_diff = trial - {1'b0, span};

  assign value_ext   = TOTAL_W'(value);
  assign suffix_base = (first_elem || suffix <= 0) ? '0 : suffix;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      run_seed <= start_seed;
      lo       <= low_bound;
      span     <= span_now;
      count_m1 <= count_eff - CW'(1);
      total    <= '0;
    end
    if (cmd.adv_run) begin
      run_seed <= lcg_out;
    end
    if (cmd.gen) begin
      elem_state <= lcg_out;
      dividend   <= lcg_out;
      rem        <= '0;
    end
    if (cmd.div_step) begin
      dividend <= {dividend[DRAW_W-2:0], 1'b0};
      if (!trial_diff[RW]) begin
        rem <= trial_diff[RW-1:0];
      end else begin
        rem <= trial[RW-1:0];
      end
    end
    if (cmd.value) begin
      value <= (VW+2)'(lo) + (VW+2)'(rem);
    end
    if (cmd.add) begin
      suffix <= suffix_base + value_ext;
    end
    if (cmd.best) begin
      if (first_elem || suffix > best) begin
        best <= suffix;
      end
    end
    if (cmd.accum) begin
      total <= total + best;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      elem_cnt <= '0;
      run_cnt  <= '0;
      div_cnt  <= '0;
    end else begin
      if (cmd.gen) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      if (cmd.best) begin
        elem_cnt <= status.last_elem ? '0 : elem_cnt + CW'(1);
      end
      if (cmd.accum) begin
        run_cnt <= run_cnt + RCOUNT_W'(1);
      end
    end
  end

  // Output register: parts the result side from the work
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.publish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      total_of_maxima <= total;
      bound_error     <= err_now;
    end
  end

  always_comb begin
    status           = '0;
    status.bound_err = err_now;
    status.no_runs   = (run_count == '0);
    status.div_last  = (div_cnt == DIV_CNT_W'(DRAW_W - 1));
    status.last_elem = (elem_cnt == count_m1);
    status.last_run  = (run_cnt == run_count - RCOUNT_W'(1));
    status.out_free  = !result_valid || !result_stall;
  end

endmodule

// File: hdl/lms_check.sv
// Port-level checks for lcg_max_subarray_total, bound to the top level.
// Sees only the top-level ports; uses lms_pkg for widths.
module lms_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               seed_valid,
  input logic                               seed_stall,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic signed [lms_pkg::TOTAL_W-1:0] total_of_maxima,
  input logic                               bound_error
);
  import lms_pkg::*;

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // A seed transfer makes the block busy next cycle
  a_busy_after_seed: assert property (@(posedge clk) disable iff (rst)
    seed_valid && !seed_stall |=> seed_stall)
    else $error("seed taken but block not busy");

  // A bound error carries a zero total
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && bound_error |-> total_of_maxima == '0)
    else $error("bound error with nonzero total");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(total_of_maxima) && $stable(bound_error))
    else $error("stalled result changed");

endmodule

bind lcg_max_subarray_total lms_check u_lms_check (
  .clk             (clk),
  .rst             (rst),
  .seed_valid      (seed_valid),
  .seed_stall      (seed_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .total_of_maxima (total_of_maxima),
  .bound_error     (bound_error)
);

// File: test/tb_lcg_max_subarray_total.sv
// Testbench for lcg_max_subarray_total: drives start seeds and configuration
// writes, predicts each total of run maxima and checks every result transfer.
// Depends on lms_pkg and the lcg_max_subarray_total RTL.
`timescale 1ns / 1ps

module tb_lcg_max_subarray_total;
  import lms_pkg::*;

  localparam int MAX_ELEMENTS   = 1048576;
  localparam int VALUE_WIDTH    = 16;
  localparam int CFG_W          = (VALUE_WIDTH > ECOUNT_W) ? VALUE_WIDTH : ECOUNT_W;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int END_CYCLES     = 50;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic                      err;
  } maxima_t;

  // Scoreboard: own copy of the registers, predicts a total per accepted seed
  class maxima_scoreboard;
    logic [ECOUNT_W-1:0]    elem_count;
    logic [VALUE_WIDTH-1:0] low_raw;
    logic [VALUE_WIDTH-1:0] high_raw;
    logic [RCOUNT_W-1:0]    runs;
    maxima_t                expected_totals[$];
    int                     mismatches;

    function new();
      elem_count = 21'd10000;
      low_raw    = -16'sd10;
      high_raw   = 16'd10;
      runs       = 8'd20;
      mismatches = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ELEMENT_COUNT: elem_count = data[ECOUNT_W-1:0];
        REG_LOW_BOUND:     low_raw    = data[VALUE_WIDTH-1:0];
        REG_HIGH_BOUND:    high_raw   = data[VALUE_WIDTH-1:0];
        REG_RUN_COUNT:     runs       = data[RCOUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DRAW_W-1:0] draw_next(logic [DRAW_W-1:0] x);
      logic [DRAW_W-1:0] y;
      y = x * LCG_MUL + LCG_ADD;
      return y;
    endfunction

    // Kadane over one run of generated values
    function longint best_stretch(logic [DRAW_W-1:0] run_seed, int unsigned count,
                                  longint lo, longint span);
      logic [DRAW_W-1:0] gen;
      longint            suffix;
      longint            best;
      longint            v;
      gen    = run_seed;
      suffix = 0;
      best   = 0;
      for (int unsigned i = 0; i < count; i++) begin
        gen = draw_next(gen);
        v   = lo + (longint'({32'd0, gen}) % span);
        if (i == 0) begin
          suffix = v;
          best   = v;
        end else begin
          suffix = ((suffix > 0) ? suffix : 0) + v;
          if (suffix > best) best = suffix;
        end
      end
      return best;
    endfunction

    function void note_seed(logic [DRAW_W-1:0] seed);
      longint            lo;
      longint            hi;
      longint            span;
      int unsigned       count;
      logic [DRAW_W-1:0] run_seed;
      logic [TOTAL_W-1:0] total;
      maxima_t           e;
      lo = $signed(low_raw);
      hi = $signed(high_raw);
      if (hi < lo) begin
        e.total = '0;
        e.err   = 1'b1;
      end else begin
        count = elem_count;
        if (count == 0) count = 1;
        if (count > MAX_ELEMENTS) count = MAX_ELEMENTS;
        span     = hi - lo + 1;
        run_seed = seed;
        total    = '0;
        for (int r = 0; r < runs; r++) begin
          run_seed = draw_next(run_seed);
          total    = total + best_stretch(run_seed, count, lo, span);
        end
        e.total = total;
        e.err   = 1'b0;
      end
      expected_totals.push_back(e);
    endfunction

    function void check_result(logic signed [TOTAL_W-1:0] total, logic err);
      maxima_t e;
      if (expected_totals.size() == 0) begin
        $display("%0t: unexpected result: total_of_maxima %0d bound_error %0b",
                 $time, total, err);
        mismatches++;
        return;
      end
      e = expected_totals.pop_front();
      if (total !== e.total) begin
        $display("%0t: total_of_maxima expected %0d actual %0d", $time, e.total, total);
        mismatches++;
      end
      if (err !== e.err) begin
        $display("%0t: bound_error expected %0b actual %0b", $time, e.err, err);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [INDEX_W-1:0]        cfg_index    = '0;
  logic [CFG_W-1:0]          cfg_data     = '0;
  logic                      seed_valid   = 1'b0;
  logic                      seed_stall;
  logic [DRAW_W-1:0]         start_seed   = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic signed [TOTAL_W-1:0] total_of_maxima;
  logic                      bound_error;

  maxima_scoreboard board = new();

  int seed_gap_pct = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  lcg_max_subarray_total #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .seed_valid     (seed_valid),
    .seed_stall     (seed_stall),
    .start_seed     (start_seed),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .total_of_maxima(total_of_maxima),
    .bound_error    (bound_error)
  );

  always #10 clk = ~clk;

  // Check each result transfer, then pick the next stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      board.check_result(total_of_maxima, bound_error);
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run after a long stretch with no transfer at all
  always @(posedge clk) begin
    if (rst || (seed_valid && !seed_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lcg_max_subarray_total: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register; leaves cfg_valid high for a following write
  task automatic write_register(reg_index_t idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_register(idx, data);
  endtask

  // Write all four registers; unused upper data bits carry noise
  task automatic configure(int count, int lo, int hi, int runs);
    write_register(REG_ELEMENT_COUNT, CFG_W'(count));
    write_register(REG_LOW_BOUND, {5'($urandom), 16'(lo)});
    write_register(REG_HIGH_BOUND, {5'($urandom), 16'(hi)});
    write_register(REG_RUN_COUNT, {13'($urandom), 8'(runs)});
    cfg_valid <= 1'b0;
  endtask

  // Offer one seed after a random gap and hold it until the transfer
  task automatic send_seed(logic [DRAW_W-1:0] seed);
    while ($urandom_range(99) < seed_gap_pct) begin
      seed_valid <= 1'b0;
      @(posedge clk);
    end
    seed_valid <= 1'b1;
    start_seed <= seed;
    @(posedge clk);
    while (seed_stall) @(posedge clk);
    board.note_seed(seed);
  endtask

  // Drop valid and wait until every predicted total has arrived
  task automatic settle();
    seed_valid <= 1'b0;
    while (board.expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly short runs; bounds ordered, reversed, wide or narrow
  task automatic random_config();
    int count;
    int lo;
    int hi;
    int runs;
    count = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
    runs  = ($urandom_range(9) == 0) ? $urandom_range(30, 7) : $urandom_range(6, 0);
    case ($urandom_range(3))
      0: begin
        lo = int'($urandom_range(65535)) - 32768;
        hi = int'($urandom_range(65535)) - 32768;
      end
      1: begin
        lo = int'($urandom_range(65535)) - 32768;
        hi = lo + int'($urandom_range(32767 - lo));
      end
      2: begin
        lo = -int'($urandom_range(20));
        hi = int'($urandom_range(20));
      end
      default: begin
        lo = int'($urandom_range(65535)) - 32768;
        hi = lo + int'($urandom_range(((32767 - lo) < 15) ? (32767 - lo) : 15));
      end
    endcase
    configure(count, lo, hi, runs);
  endtask

  initial begin
    int gap_by_phase[4];
    int stall_by_phase[4];
    gap_by_phase   = '{0, 53, 0, 22};
    stall_by_phase = '{0, 0, 53, 22};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default bounds and run count, short runs
    write_register(REG_ELEMENT_COUNT, CFG_W'(3));
    cfg_valid <= 1'b0;
    send_seed(32'h0000_0000);
    send_seed(32'hFFFF_FFFF);
    settle();

    // Widest span, single element, single run
    configure(1, -32768, 32767, 1);
    send_seed(32'h0000_0000);
    send_seed(32'hFFFF_FFFF);
    send_seed(32'h8000_0000);
    send_seed($urandom);
    settle();

    // Zero element count acts as one; equal bounds give span one
    configure(0, 5, 5, 3);
    send_seed($urandom);
    settle();

    // Reversed bounds
    configure(4, 10, -10, 5);
    send_seed(32'h0000_0002);
    settle();

    // Reversed at the extremes; count above the maximum and full run count
    configure(21'h1F_FFFF, 32767, -32768, 255);
    send_seed(32'h0000_0001);
    settle();

    // Zero run count at the largest element count
    configure(MAX_ELEMENTS, -3, 3, 0);
    send_seed($urandom);
    settle();

    // Most negative total, then the largest single-element total
    configure(1, -32768, -32768, 255);
    send_seed($urandom);
    settle();
    configure(1, 32767, 32767, 255);
    send_seed($urandom);
    settle();

    // Longer mixed runs, all-negative runs
    configure(40, -5, 3, 4);
    send_seed($urandom);
    send_seed($urandom);
    settle();
    configure(24, -32768, 32767, 2);
    send_seed($urandom);
    settle();
    configure(12, -100, -1, 3);
    send_seed($urandom);
    settle();

    // Random part: four phases of seed gaps and result stalls, new settings every five seeds
    for (int p = 0; p < 4; p++) begin
      seed_gap_pct = gap_by_phase[p];
      stall_pct    = stall_by_phase[p];
      for (int g = 0; g < 5; g++) begin
        random_config();
        for (int k = 0; k < 5; k++) send_seed($urandom);
        settle();
      end
    end

    stall_pct = 0;
    repeat (END_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_totals.size() == 0)
      $display("lcg_max_subarray_total: match");
    else
      $display("lcg_max_subarray_total: mismatch");
    $finish;
  end

endmodule

// File: files.f
hdl/lms_pkg.sv
hdl/lms_ctrl.sv
hdl/lms_dpath.sv
hdl/lcg_max_subarray_total.sv
hdl/lms_check.sv
test/tb_lcg_max_subarray_total.sv
